FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define APE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define APE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ape_pkg.sv
// Package of the peak envelope LED unit: sizes, codes, job and state types.
// No dependencies.
package ape_pkg;

   localparam int HISTORY_DEPTH  = 512;
   localparam int SILENCE_FRAMES = 75;

   localparam int HIST_ADDR_W = $clog2(HISTORY_DEPTH);
   localparam int HIST_CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SIL_W       = $clog2(SILENCE_FRAMES + 1);
   localparam int CALC_W      = HIST_CNT_W + 10;

   localparam int DIV_NUM_W = 42;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LATENCY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE     = 3'd5;

   localparam logic [13:0] THRESHOLD_RESET = 14'h38F8;
   localparam logic [15:0] ATTACK_RESET    = 16'd39322;
   localparam logic [15:0] DECAY_RESET     = 16'd3604;

   localparam logic [15:0] PEAK_MAX   = 16'd32768;
   localparam logic [16:0] LOG_SCALE  = 17'd105218;
   localparam logic [15:0] ENV_FLOOR  = 16'd33;
   localparam logic [15:0] THR_CAP    = 16'd65470;
   localparam logic [14:0] LOOP_MS    = 15'd20000;
   localparam logic [14:0] PHASE_MAX  = 15'd19999;

   // The threshold is (off * 4096 + 187) / 375 and the hue blend is
   // ((2 * prod + 65536 * 20000) >> 22) / 625, both by reciprocal multiplication.
   localparam logic [24:0] THR_ROUND = 25'd187;
   localparam logic [25:0] THR_RECIP = 26'd45812985;
   localparam logic [40:0] X_BIAS    = 41'd1310720000;
   localparam logic [18:0] X_RECIP   = 19'd429497;

   typedef struct packed {
      logic        is_clear;
      logic        audio;
      logic [15:0] peak;
      logic [14:0] phase;
   } ape_job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG,
      ST_SCALE_MUL,
      ST_SCALE,
      ST_ENV_MUL,
      ST_ENV,
      ST_WRITE,
      ST_READ,
      ST_THR_START,
      ST_THR_WAIT,
      ST_V_START,
      ST_V_WAIT,
      ST_X_MUL,
      ST_X_START,
      ST_X_WAIT,
      ST_EMIT
   } ape_state_type;

endpackage

FILE: hw/rtl/ape_if.sv
// Channel interfaces of the peak envelope LED unit: request, response and CSR write.
// Depends on ape_pkg.
interface ape_req_if;
   import ape_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [15:0] sample;
   logic [14:0]        color_phase_ms;
   modport source (output valid, op, sample, color_phase_ms, input ready);
   modport sink (input valid, op, sample, color_phase_ms, output ready);
endinterface

interface ape_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       audio_shown;
   modport source (output valid, red, green, blue, audio_shown, input ready);
   modport sink (input valid, red, green, blue, audio_shown, output ready);
endinterface

interface ape_csr_if;
   import ape_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/ape_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ape_pkg.
module ape_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ape_pkg::DIV_NUM_W-1:0] num,
   input  logic [ape_pkg::DIV_DEN_W-1:0] den,
   output logic                          done,
   output logic [ape_pkg::DIV_NUM_W-1:0] quo
);
   import ape_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 ge;
   logic [DIV_DEN_W:0]   rem_diff;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      ge       = rem_sh >= {1'b0, den_ff};
      rem_diff = rem_sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

FILE: hw/rtl/ape_fifo.sv
// Two-entry job queue between the front end and the frame engine.
// Depends on ape_pkg.
module ape_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ape_pkg::ape_job_type push_job,
   input  logic                 pop,
   output ape_pkg::ape_job_type head_job,
   output logic                 full,
   output logic                 empty
);
   import ape_pkg::*;

   ape_job_type mem_ff [2];
   logic        wr_ff;
   logic        rd_ff;
   logic [1:0]  cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

   assign head_job = mem_ff[rd_ff];
   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
endmodule

FILE: hw/rtl/ape_front.sv
// Front end: takes request transactions, tracks peak and silence, queues frame jobs.
// Depends on ape_pkg and ape_if.
module ape_front (
   input  logic                 clock,
   input  logic                 reset,
   ape_req_if.sink              req,
   input  logic                 q_full,
   output logic                 q_push,
   output ape_pkg::ape_job_type q_job
);
   import ape_pkg::*;

   logic [15:0]      peak_ff;
   logic [SIL_W-1:0] sil_ff;
   logic             accept;
   logic [15:0]      mag;
   logic             audio;

   always_comb begin
      accept = req.valid && req.ready;
      mag    = req.sample[15] ? 16'(~req.sample + 16'sd1) : 16'(req.sample);
      audio  = sil_ff < SIL_W'(SILENCE_FRAMES);
      q_push = accept && (req.op == OP_TICK || req.op == OP_CLEAR);
      q_job.is_clear = req.op == OP_CLEAR;
      q_job.audio    = audio;
      q_job.peak     = peak_ff;
      q_job.phase    = req.color_phase_ms;
   end

   assign req.ready = !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
         sil_ff  <= SIL_W'(SILENCE_FRAMES);
      end else if (accept) begin
         case (req.op)
            OP_SAMPLE: begin
               if (mag > peak_ff) peak_ff <= mag;
               sil_ff <= '0;
            end
            OP_TICK: begin
               peak_ff <= '0;
               if (audio) sil_ff <= sil_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end
endmodule

FILE: hw/rtl/ape_back.sv
// Frame engine: log level, envelope, delay line, brightness ramp and hue to RGB.
// Depends on ape_pkg, ape_if and ape_div.
module ape_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ape_pkg::ape_job_type job,
   input  logic                 job_valid,
   output logic                 job_pop,
   ape_csr_if.sink              csr,
   ape_rsp_if.source            rsp
);
   import ape_pkg::*;

   ape_state_type state_ff, state_in;

   logic signed [13:0] thr_cfg_ff;
   logic [8:0]         lat_ff;
   logic [15:0]        att_ff;
   logic [15:0]        dec_ff;

   logic                   audio_ff;
   logic                   zero_ff;
   logic [14:0]            phase_ff;
   logic [16:0]            x_ff;
   logic [3:0]             e_ff;
   logic [15:0]            frac_ff;
   logic [3:0]             cnt_ff;
   logic [36:0]            prod_ff;
   logic [15:0]            target_ff;
   logic                   up_ff;
   logic [15:0]            lvl_ff;
   logic [HIST_ADDR_W-1:0] wp_ff;
   logic [HIST_CNT_W-1:0]  fw_ff;
   logic [HIST_ADDR_W-1:0] slot_ff;
   logic [16:0]            entry_ff;
   logic [16:0]            hist_ff [HISTORY_DEPTH];
   logic [50:0]            thr_mul_ff;
   logic [15:0]            thr_ff;
   logic [16:0]            v_ff;
   logic [2:0]             sext_ff;
   logic [7:0]             cc_ff;
   logic [7:0]             xx_ff;
   logic [39:0]            xprod_ff;
   logic [36:0]            xmul_ff;
   logic                   out_valid_ff;
   logic [7:0]             red_ff, green_ff, blue_ff;
   logic [7:0]             red_in, green_in, blue_in;
   logic                   shown_ff;

   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quo;
   logic                 mem_we;
   logic                 mem_re;
   logic                 out_free;

   logic [15:0] pk;
   logic [3:0]  pk_e;
   logic [16:0] x0;
   logic [33:0] sq;
   logic [18:0] sq_t;
   logic [19:0] delta;
   logic [17:0] p2;
   logic [16:0] step;
   logic [16:0] nl;
   logic signed [14:0] thr_c;
   logic [12:0] thr_off;
   logic [24:0] thr_t;
   logic [15:0] lvl_e;
   logic [15:0] seg_num;
   logic [16:0] seg_den;
   logic [23:0] seg_sum;
   logic [14:0] ph;
   logic [16:0] scaled;
   logic [2:0]  sext;
   logic [16:0] g0;
   logic [14:0] g;
   logic [24:0] v255;
   logic [25:0] cc_sum;
   logic [40:0] x_sum;
   logic [CALC_W-1:0]      dly;
   logic [HIST_ADDR_W:0]   slot_w;

   ape_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_cfg_ff <= THRESHOLD_RESET;
         lat_ff     <= '0;
         att_ff     <= ATTACK_RESET;
         dec_ff     <= DECAY_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            REG_THRESHOLD: thr_cfg_ff <= csr.data[13:0];
            REG_LATENCY:   lat_ff     <= csr.data[8:0];
            REG_ATTACK:    att_ff     <= csr.data;
            REG_DECAY:     dec_ff     <= csr.data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pk   = (job.peak > PEAK_MAX) ? PEAK_MAX : job.peak;
      pk_e = '0;
      for (int i = 0; i < 16; i++) begin
         if (pk[i]) pk_e = 4'(i);
      end
      x0 = {1'b0, pk << (4'd15 - pk_e)};

      sq    = 34'(x_ff) * 34'(x_ff);
      sq_t  = sq[33:15];
      delta = 20'(15 << 16) - {e_ff, frac_ff};
      p2    = 18'((prod_ff + 37'(1 << 19)) >> 20);
      step  = 17'((33'(prod_ff[31:0]) + 33'd32768) >> 16);
      nl    = up_ff ? 17'(lvl_ff) + step : 17'(lvl_ff) - step;

      if (thr_cfg_ff < -14'sd6000) thr_c = -15'sd6000;
      else if (thr_cfg_ff > 14'sd0) thr_c = 15'sd0;
      else thr_c = 15'(thr_cfg_ff);
      thr_off = 13'(thr_c + 15'sd6000);
      thr_t   = {thr_off, 12'b0} + THR_ROUND;

      lvl_e   = entry_ff[15:0];
      seg_num = lvl_e - thr_ff;
      seg_den = 17'h10000 - 17'(thr_ff);
      seg_sum = 24'(seg_den) * 24'd12 + 24'(seg_num) * 24'd88;

      ph     = (phase_ff > PHASE_MAX) ? PHASE_MAX : phase_ff;
      scaled = 17'(ph) * 17'd6;
      if (scaled >= 17'd100000) sext = 3'd5;
      else if (scaled >= 17'd80000) sext = 3'd4;
      else if (scaled >= 17'd60000) sext = 3'd3;
      else if (scaled >= 17'd40000) sext = 3'd2;
      else if (scaled >= 17'd20000) sext = 3'd1;
      else sext = 3'd0;
      g0 = scaled - 17'(sext) * 17'(LOOP_MS);
      g  = sext[0] ? LOOP_MS - g0[14:0] : g0[14:0];
      v255   = (25'(v_ff) << 8) - 25'(v_ff);
      cc_sum = 26'(v255) + 26'd32768;
      x_sum  = {xprod_ff, 1'b0} + X_BIAS;

      dly = CALC_W'(lat_ff);
      if (dly > CALC_W'(HISTORY_DEPTH - 1)) dly = CALC_W'(HISTORY_DEPTH - 1);
      if (dly > CALC_W'(fw_ff)) dly = CALC_W'(fw_ff);
      if ({1'b0, wp_ff} >= (HIST_ADDR_W + 1)'(dly)) begin
         slot_w = {1'b0, wp_ff} - (HIST_ADDR_W + 1)'(dly);
      end else begin
         slot_w = {1'b0, wp_ff} + (HIST_ADDR_W + 1)'(HISTORY_DEPTH) - (HIST_ADDR_W + 1)'(dly);
      end
   end

   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      if (entry_ff[16]) begin
         case (sext_ff)
            3'd0: begin red_in = cc_ff; green_in = xx_ff; end
            3'd1: begin red_in = xx_ff; green_in = cc_ff; end
            3'd2: begin green_in = cc_ff; blue_in = xx_ff; end
            3'd3: begin green_in = xx_ff; blue_in = cc_ff; end
            3'd4: begin red_in = xx_ff; blue_in = cc_ff; end
            default: begin red_in = cc_ff; blue_in = xx_ff; end
         endcase
      end
   end

   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (job_valid && !job.is_clear) state_in = ST_LOG;
         ST_LOG:       if (cnt_ff == 4'd15) state_in = ST_SCALE_MUL;
         ST_SCALE_MUL: state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_ENV_MUL;
         ST_ENV_MUL:   state_in = ST_ENV;
         ST_ENV:       state_in = ST_WRITE;
         ST_WRITE:     state_in = ST_READ;
         ST_READ:      state_in = ST_THR_START;
         ST_THR_START: state_in = entry_ff[16] ? ST_THR_WAIT : ST_EMIT;
         ST_THR_WAIT:  state_in = ST_V_START;
         ST_V_START: begin
            if (lvl_e <= thr_ff && thr_ff == '0) state_in = ST_X_MUL;
            else state_in = ST_V_WAIT;
         end
         ST_V_WAIT:    if (div_done) state_in = ST_X_MUL;
         ST_X_MUL:     state_in = ST_X_START;
         ST_X_START:   state_in = ST_X_WAIT;
         ST_X_WAIT:    state_in = ST_EMIT;
         ST_EMIT:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      job_pop   = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      case (state_ff)
         ST_IDLE:  job_pop = job_valid;
         ST_WRITE: mem_we = 1'b1;
         ST_READ:  mem_re = 1'b1;
         ST_V_START: begin
            if (lvl_e <= thr_ff) begin
               div_start = thr_ff != '0;
               div_num   = DIV_NUM_W'({lvl_e, 15'b0}) + DIV_NUM_W'(thr_ff) * DIV_NUM_W'(5);
               div_den   = DIV_DEN_W'(thr_ff) * DIV_DEN_W'(10);
            end else begin
               div_start = 1'b1;
               div_num   = DIV_NUM_W'({seg_sum, 17'b0}) + DIV_NUM_W'(seg_den) * DIV_NUM_W'(100);
               div_den   = DIV_DEN_W'(seg_den) * DIV_DEN_W'(200);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lvl_ff       <= '0;
         wp_ff        <= '0;
         fw_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EMIT && out_free) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (job_valid && job.is_clear) begin
                  wp_ff <= '0;
                  fw_ff <= '0;
               end
            end
            ST_ENV: lvl_ff <= (nl < 17'(ENV_FLOOR)) ? '0 : nl[15:0];
            ST_WRITE: begin
               wp_ff <= (wp_ff == HIST_ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
               if (fw_ff < HIST_CNT_W'(HISTORY_DEPTH)) fw_ff <= fw_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            audio_ff <= job.audio;
            zero_ff  <= !job.audio || pk == '0;
            phase_ff <= job.phase;
            x_ff     <= x0;
            e_ff     <= pk_e;
            frac_ff  <= '0;
            cnt_ff   <= '0;
         end
         ST_LOG: begin
            cnt_ff  <= cnt_ff + 1'b1;
            frac_ff <= {frac_ff[14:0], sq_t[16]};
            x_ff    <= sq_t[16] ? sq_t[17:1] : sq_t[16:0];
         end
         ST_SCALE_MUL: prod_ff <= 37'(delta) * 37'(LOG_SCALE);
         ST_SCALE: begin
            if (zero_ff || p2 >= 18'h10000) target_ff <= '0;
            else if (p2 == '0) target_ff <= 16'hFFFF;
            else target_ff <= 16'(18'h10000 - p2);
         end
         ST_ENV_MUL: begin
            up_ff   <= target_ff > lvl_ff;
            prod_ff <= 37'(target_ff > lvl_ff ? target_ff - lvl_ff : lvl_ff - target_ff)
                       * 37'(target_ff > lvl_ff ? att_ff : dec_ff);
         end
         ST_WRITE: slot_ff <= slot_w[HIST_ADDR_W-1:0];
         ST_THR_START: thr_mul_ff <= 51'(thr_t) * 51'(THR_RECIP);
         ST_THR_WAIT: begin
            thr_ff <= (thr_mul_ff[50:34] >= 17'h10000) ? THR_CAP : thr_mul_ff[49:34];
         end
         ST_V_START: if (lvl_e <= thr_ff && thr_ff == '0) v_ff <= '0;
         ST_V_WAIT: if (div_done) v_ff <= div_quo[16:0];
         ST_X_MUL: begin
            sext_ff  <= sext;
            cc_ff    <= cc_sum[23:16];
            xprod_ff <= 40'(v255) * 40'(g);
         end
         ST_X_START: xmul_ff <= 37'(x_sum[39:22]) * 37'(X_RECIP);
         ST_X_WAIT: xx_ff <= xmul_ff[35:28];
         ST_EMIT: begin
            if (out_free) begin
               shown_ff <= entry_ff[16];
               red_ff   <= red_in;
               green_ff <= green_in;
               blue_ff  <= blue_in;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) hist_ff[wp_ff] <= {audio_ff, lvl_ff};
      if (mem_re) entry_ff <= hist_ff[slot_ff];
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.red         = red_ff;
   assign rsp.green       = green_ff;
   assign rsp.blue        = blue_ff;
   assign rsp.audio_shown = shown_ff;
endmodule

FILE: hw/rtl/audio_peak_led_envelope_unit.sv
// Top level of the peak envelope LED unit: front end, job queue and frame engine.
// Depends on ape_pkg, ape_if, ape_front, ape_fifo and ape_back.
//
// Sample transactions only update the peak and silence state. A frame tick passes
// through a two-entry queue to the frame engine, which loads the pixel after log2
// squaring, envelope, delay line and threshold arithmetic, one pass of the
// bit-serial divider for the brightness ramp, and hue arithmetic. A frame whose
// delayed entry has no audio skips the threshold, divider and hue steps, and one
// whose threshold and level are both zero skips the divider. A clear only resets
// the delay line in the idle state. While the queue is full, no request
// transaction is accepted. The response sits in an output register so the engine
// can start on the next job while the previous pixel waits to be taken.
module audio_peak_led_envelope_unit (
   input logic       clock,
   input logic       reset,
   ape_req_if.sink   req_bus,
   ape_rsp_if.source rsp_bus,
   ape_csr_if.sink   csr_bus
);
   import ape_pkg::*;

   ape_job_type push_job;
   ape_job_type head_job;
   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;

   ape_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (push_job)
   );

   ape_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   ape_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .job_valid (!q_empty),
      .job_pop   (q_pop),
      .csr       (csr_bus),
      .rsp       (rsp_bus)
   );
endmodule

FILE: hw/rtl/ape_checker.sv
// Port-level checks of the peak envelope LED unit and the bind that attaches them.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ape_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_audio_shown
);
   `APE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `APE_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue), "response changed while stalled")
   `APE_ASSERT_IMP(a_black, clock, reset, rsp_valid && !rsp_audio_shown, rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0, "pixel not black without audio")
   `APE_ASSERT_IMP(a_hue_zero, clock, reset, rsp_valid, rsp_red == 8'd0 || rsp_green == 8'd0 || rsp_blue == 8'd0, "full saturation color has no zero channel")
   `APE_ASSERT_IMP(a_reset_idle, clock, reset, $past(reset), !rsp_valid, "response valid right after reset")
endmodule

bind audio_peak_led_envelope_unit ape_checker u_ape_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_red         (rsp_bus.red),
   .rsp_green       (rsp_bus.green),
   .rsp_blue        (rsp_bus.blue),
   .rsp_audio_shown (rsp_bus.audio_shown)
);
